### design/ple_pkg.sv
package ple_pkg;

	// List geometry
	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int PW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // cell index bits
	localparam int CW          = $clog2(DEPTH + 1);                // count bits

	// Command codes
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_INSERT     = 3'd2,
		CMD_ERASE      = 3'd3,
		CMD_READ       = 3'd4
	} cmd_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Input item
	typedef struct packed {
		logic [2:0]          command;
		logic signed [31:0]  value;
		logic signed [15:0]  position;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [1:0]          status;
		logic [4:0]          entry_count;
		logic signed [31:0]  read_value;
	} out_item_t;

	// Decoded per-item control for the cell array
	typedef struct packed {
		logic           ins;
		logic           ers;
		logic           rd;
		logic [PW-1:0]  pos;
		logic [CW-1:0]  cnt_nxt;
		logic [1:0]     status;
	} ctrl_t;

	// 32-bit input value to stored width
	function automatic logic [VALUE_WIDTH-1:0] widen_value(input logic signed [31:0] v);
		logic signed [63:0] t;
		t = 64'(v);
		return t[VALUE_WIDTH-1:0];
	endfunction

	// Stored value back to 32 bits
	function automatic logic [31:0] narrow_value(input logic signed [VALUE_WIDTH-1:0] v);
		logic signed [63:0] t;
		t = 64'(v);
		return t[31:0];
	endfunction

	// Negative goes to the front, past the limit goes to the limit
	function automatic logic [CW-1:0] clamp_pos(input logic signed [15:0] p,
			input logic [CW-1:0] lim);
		logic [15:0] pu;
		pu = p;
		if (pu[15])
			return '0;
		else if (pu > 16'(lim))
			return lim;
		else
			return pu[CW-1:0];
	endfunction

endpackage

### design/ple_decode.sv
module ple_decode
	import ple_pkg::*;
(
	input  logic          valid,
	input  in_item_t      item,
	input  logic [CW-1:0] count,
	output ctrl_t         ctrl
);

	logic          full;
	logic          empty;
	logic [CW-1:0] last;
	logic [CW-1:0] pos_ins;
	logic [CW-1:0] pos_last;

	assign full     = (count == CW'(DEPTH));
	assign empty    = (count == '0);
	assign last     = count - CW'(1);
	assign pos_ins  = clamp_pos(item.position, count);
	assign pos_last = clamp_pos(item.position, last);

	// Command decode against the current count
	always_comb begin
		ctrl         = '0;
		ctrl.cnt_nxt = count;
		ctrl.status  = ST_DONE;
		unique case (cmd_t'(item.command))
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
				if (full) begin
					ctrl.status = ST_FULL;
				end else begin
					ctrl.ins     = valid;
					ctrl.cnt_nxt = count + CW'(1);
					if (cmd_t'(item.command) == CMD_PUSH_FRONT)
						ctrl.pos = '0;
					else if (cmd_t'(item.command) == CMD_PUSH_BACK)
						ctrl.pos = count[PW-1:0];
					else
						ctrl.pos = pos_ins[PW-1:0];
				end
			end
			CMD_ERASE: begin
				if (empty) begin
					ctrl.status = ST_EMPTY;
				end else begin
					ctrl.ers     = valid;
					ctrl.cnt_nxt = last;
					ctrl.pos     = pos_last[PW-1:0];
				end
			end
			CMD_READ: begin
				if (empty) begin
					ctrl.status = ST_EMPTY;
				end else begin
					ctrl.rd  = 1'b1;
					ctrl.pos = pos_last[PW-1:0];
				end
			end
			default: begin
				// unused codes leave the list alone
			end
		endcase
	end

endmodule

### design/ple_cells.sv
module ple_cells
	import ple_pkg::*;
(
	input  logic                   clk,
	input  ctrl_t                  ctrl,
	input  logic [VALUE_WIDTH-1:0] wr_value,
	output logic [31:0]            rd_value
);

	logic [VALUE_WIDTH-1:0] cell_q [DEPTH];

	// Insert shifts cells above pos up; erase shifts cells from pos on down
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctrl.ins) begin
				if (PW'(gi) == ctrl.pos)
					cell_q[gi] <= wr_value;
				else if (gi > 0 && PW'(gi) > ctrl.pos)
					cell_q[gi] <= cell_q[(gi > 0) ? gi - 1 : 0];
			end else if (ctrl.ers) begin
				if (gi < DEPTH - 1 && PW'(gi) >= ctrl.pos)
					cell_q[gi] <= cell_q[(gi < DEPTH - 1) ? gi + 1 : gi];
			end
		end
	end

	// Read port, state before this item's update
	assign rd_value = narrow_value(cell_q[ctrl.pos]);

endmodule

### design/positional_list_engine.sv
// Channel   Ports                  Handshake
// -------   --------------------   -----------------------------------------
// command   start, busy, cmd       taken at clk edge with start high, busy low
// result    done, rsp              done high for one cycle, rsp valid then
//
// One command per cycle; busy stays low. A result passes through the input
// register and then the result register. The cell array shifts all entries
// at once, so each command finishes while it sits in the input register.
// The receiver cannot stall.
// Reset clears the count and the pipeline valid bits; list cells are not
// cleared and are only read below the count.
module positional_list_engine
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  cmd,
	output logic      done,
	output out_item_t rsp
);

	logic          valid_s1;
	in_item_t      item_s1;
	logic [CW-1:0] count_q;
	ctrl_t         ctrl;
	logic [31:0]   rd_value;
	logic          done_q;
	out_item_t     rsp_q;

	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			item_s1 <= cmd;
	end

	ple_decode u_decode (
		.valid (valid_s1),
		.item  (item_s1),
		.count (count_q),
		.ctrl  (ctrl)
	);

	ple_cells u_cells (
		.clk      (clk),
		.ctrl     (ctrl),
		.wr_value (widen_value(item_s1.value)),
		.rd_value (rd_value)
	);

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (valid_s1)
			count_q <= ctrl.cnt_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.status      <= ctrl.status;
			rsp_q.entry_count <= 5'(ctrl.cnt_nxt);
			rsp_q.read_value  <= ctrl.rd ? rd_value : 32'sd0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("result lost after item");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctrl.status == ST_FULL) |=> count_q == CW'(DEPTH))
		else $error("full status with count below depth");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctrl.status == ST_EMPTY) |-> count_q == '0)
		else $error("empty status with entries present");
`endif

endmodule

### dv/ple_list_checker.sv
module ple_list_checker
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  in_item_t  cmd,
	input  logic      done,
	input  out_item_t rsp,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the list
	logic [VALUE_WIDTH-1:0] cells [DEPTH];
	int unsigned            fill;

	// Results owed by the block, oldest first
	out_item_t rsp_due [$];

	// Negative goes to the front, past the limit sticks at the limit
	function automatic int unsigned clamp_index(input logic [15:0] p, input int unsigned lim);
		if (p[15])
			return 0;
		if (p > lim)
			return lim;
		return p;
	endfunction

	// Apply one command to the shadow list and build the result it owes
	task automatic run_command(input in_item_t it, output out_item_t res);
		int unsigned            at;
		int unsigned            i;
		logic signed [63:0]     wide;
		logic [VALUE_WIDTH-1:0] stored;
		wide   = 64'($signed(it.value));
		stored = wide[VALUE_WIDTH-1:0];
		res    = '0;
		case (it.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
				if (fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					if (it.command == CMD_PUSH_FRONT)
						at = 0;
					else if (it.command == CMD_PUSH_BACK)
						at = fill;
					else
						at = clamp_index(it.position, fill);
					for (i = fill; i > at; i--)
						cells[i] = cells[i-1];
					cells[at] = stored;
					fill++;
				end
			end
			CMD_ERASE: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					at = clamp_index(it.position, fill - 1);
					for (i = at; i + 1 < fill; i++)
						cells[i] = cells[i+1];
					fill--;
				end
			end
			CMD_READ: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					at             = clamp_index(it.position, fill - 1);
					wide           = 64'($signed(cells[at]));
					res.read_value = wide[31:0];
				end
			end
			default: ;  // spare codes change nothing
		endcase
		res.entry_count = 5'(fill);
	endtask

	// Check results first, then log the item taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t owed;
		if (!arst_n) begin
			rsp_due.delete();
			fill    = 0;
			errors  = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					$display("%0t: result with nothing outstanding: status %0d count %0d value %0d",
						$time, rsp.status, rsp.entry_count, rsp.read_value);
					errors++;
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						errors++;
					end
					if (rsp.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, rsp.entry_count);
						errors++;
					end
					if (rsp.read_value !== want.read_value) begin
						$display("%0t: read_value expected %0d actual %0d",
							$time, want.read_value, rsp.read_value);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				run_command(cmd, owed);
				rsp_due.insert(rsp_due.size(), owed);
			end
			pending <= rsp_due.size();
		end
	end

endmodule

### dv/tb_positional_list_engine.sv
module tb_positional_list_engine;
	import ple_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int         RANDOM_ITEMS    = 640;
	localparam int         QUIET_LIMIT     = 2000;
	localparam int         DRAIN_CYCLES    = 6;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  cmd;
	logic      done;
	out_item_t rsp;
	int        errors;
	int        pending;
	int        quiet = 0;
	int        gap_pct;

	positional_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	ple_list_checker list_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: too long without any item or result moving
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one item after a random gap, return once it is taken
	task automatic send_item(input logic [2:0] op, input logic [31:0] val,
			input logic [15:0] pos);
		in_item_t it;
		it.command  = op;
		it.value    = val;
		it.position = pos;
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Mostly positions near the live range, some negative, large or extreme
	function automatic logic [15:0] pick_position();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, DEPTH + 2));
			6:                return 16'($urandom_range(32768, 65535));
			7:                return 16'($urandom);
			8:                return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default:          return 16'($urandom_range(DEPTH, 32767));
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// grow_pct: share of commands that add an entry
	function automatic logic [2:0] pick_command(input int grow_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		if (r < 3 + grow_pct) begin
			case ($urandom_range(0, 2))
				0:       return CMD_PUSH_FRONT;
				1:       return CMD_PUSH_BACK;
				default: return CMD_INSERT;
			endcase
		end
		return ($urandom_range(0, 99) < 60) ? CMD_ERASE : CMD_READ;
	endfunction

	initial begin
		int idle_plan [4];
		int burst_left;
		int grow_pct;
		idle_plan  = '{0, 54, 0, 12};
		burst_left = 0;
		grow_pct   = 50;
		gap_pct    = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		cmd    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, clamping at both ends, spare codes, erase down to empty
		send_item(CMD_READ, 32'h0, 16'h0);
		send_item(CMD_ERASE, 32'h0, 16'h0);
		send_item(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 16'h0);
		send_item(CMD_PUSH_BACK, 32'h8000_0000, 16'h7FFF);
		send_item(CMD_INSERT, 32'hFFFF_FFFF, 16'h8000);
		send_item(CMD_INSERT, 32'h0, 16'h7FFF);
		send_item(CMD_INSERT, 32'h1234_5678, 16'h1);
		send_item(CMD_READ, 32'h0, 16'hFFFF);
		send_item(CMD_READ, 32'h0, 16'h7FFF);
		send_item(CMD_READ, 32'h0, 16'h2);
		send_item(CMD_SPARE_FIRST, 32'hFFFF_FFFF, 16'h1);
		send_item(CMD_SPARE_MID, 32'h5555_AAAA, 16'h8000);
		send_item(CMD_SPARE_LAST, 32'hAAAA_5555, 16'h7FFF);
		send_item(CMD_ERASE, 32'h0, 16'h0);
		send_item(CMD_ERASE, 32'h0, 16'h7FFF);
		send_item(CMD_ERASE, 32'h0, 16'h8000);
		send_item(CMD_ERASE, 32'h0, 16'h0);
		send_item(CMD_READ, 32'h0, 16'h0);
		send_item(CMD_ERASE, 32'h0, 16'h0);
		send_item(CMD_READ, 32'h0, 16'h3);

		// Random: bursts that lean toward filling or draining the list
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct = idle_plan[ph];
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(20, 60);
					case ($urandom_range(0, 2))
						0:       grow_pct = 70;
						1:       grow_pct = 25;
						default: grow_pct = 45;
					endcase
				end
				burst_left--;
				send_item(pick_command(grow_pct), pick_value(), pick_position());
			end
		end

		// Let the last results come back
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
design/ple_pkg.sv
design/ple_decode.sv
design/ple_cells.sv
design/positional_list_engine.sv
dv/ple_list_checker.sv
dv/tb_positional_list_engine.sv
